[sv/rpbc_pkg.sv]
// ----------------------------------------------------------------------------
// rpbc_pkg: shared types and constants of the rgb555 blend/convert engine
// Action codes, register indexes, alpha widths and small pixel helpers.
// ----------------------------------------------------------------------------
package rpbc_pkg;

  // palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);

  // configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // alpha scale: 65536 is fully opaque
  localparam int          ALPHA_W   = 17;
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  // tint alpha scale: 4096 is fully opaque
  localparam logic [12:0] TINT_ALPHA_ONE = 13'd4096;

  // pixel actions
  typedef enum logic [2:0] {
    ACT_PAL_WRITE     = 3'd0,
    ACT_BGRA_CONVERT  = 3'd1,
    ACT_BGRA_BLEND    = 3'd2,
    ACT_INDEX_CONVERT = 3'd3,
    ACT_INDEX_BLEND   = 3'd4,
    ACT_ALPHA_WHITE   = 3'd5,
    ACT_ALPHA_TINT    = 3'd6
  } action_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_ALPHA = 8'd3;

  // five-bit white level
  localparam logic [4:0] CHAN_FULL = 5'h1F;

  // flat tint settings
  typedef struct packed {
    logic [4:0]  red;
    logic [4:0]  green;
    logic [4:0]  blue;
    logic [12:0] alpha;
  } tint_cfg_t;

  // one accepted pixel request
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] color;
    logic [7:0]  code;
    logic [15:0] dst;
    logic        pal_ok;
  } pix_req_t;

  // byte swap of a 16-bit pixel
  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // floor(a * 65536 / 255) = a * 257 plus one when a is 255
  function automatic logic [ALPHA_W-1:0] widen_alpha(input logic [7:0] a);
    return {1'b0, a, a} + ALPHA_W'(a == 8'hFF);
  endfunction

  // keep top five bits of each channel, then byte swap
  function automatic logic [15:0] convert_word(input logic [31:0] col);
    return swap16({col[7:3], col[15:11], 1'b0, col[23:19]});
  endfunction

endpackage

[sv/rpbc_palette_mem.sv]
// ----------------------------------------------------------------------------
// rpbc_palette_mem: palette store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module rpbc_palette_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [rpbc_pkg::PAL_IDX_W-1:0] wr_addr,
  input  logic [31:0]                   wr_data,
  input  logic                          rd_en,
  input  logic [rpbc_pkg::PAL_IDX_W-1:0] rd_addr,
  output logic [31:0]                   rd_data
);
  import rpbc_pkg::*;

  logic [31:0] mem [PALETTE_ENTRIES];

  // a write takes effect at the clock edge, so a read
  // issued the cycle after a write already sees the new entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/rpbc_blend_pipe.sv]
// ----------------------------------------------------------------------------
// rpbc_blend_pipe: pixel blend and convert pipeline
// Colour select and alpha widening, scaling products, sum and pack, output.
// ----------------------------------------------------------------------------
module rpbc_blend_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_load,
  input  rpbc_pkg::pix_req_t  req,
  output logic                in_ready,
  input  logic [31:0]         pal_data,
  input  rpbc_pkg::tint_cfg_t tint,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_pixel
);
  import rpbc_pkg::*;

  typedef struct packed {
    logic [2:0]         action;
    logic [23:0]        rgb;
    logic [15:0]        dst;
    logic [15:0]        conv;
    logic [ALPHA_W-1:0] alpha;
    logic [ALPHA_W-1:0] tint_a;
  } s2_t;

  typedef struct packed {
    logic        conv_sel;
    logic [15:0] conv;
    logic [21:0] back_r;
    logic [21:0] back_g;
    logic [21:0] back_b;
    logic [24:0] src_r;
    logic [24:0] src_g;
    logic [24:0] src_b;
  } s3_t;

  pix_req_t s1;
  s2_t      s2, s2_next;
  s3_t      s3, s3_next;
  logic     v1, v2, v3;
  logic     rdy2, rdy3, rdy4;
  logic     produces;

  // per-stage flow control
  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;

  // palette writes and the unused action leave no result
  assign produces = (req.action != ACT_PAL_WRITE) && (req.action <= ACT_ALPHA_TINT);

  // stage 1 capture, aligned with the palette read
  always_ff @(posedge clk) begin
    if (in_load) begin
      s1 <= req;
    end
  end

  // stage 1: select colour, widen alpha, scale by tint alpha
  always_comb begin
    logic [31:0]        col;
    logic [7:0]         a_byte;
    logic [ALPHA_W-1:0] w;
    logic [12:0]        ta;
    logic [29:0]        tprod;
    if ((s1.action == ACT_INDEX_CONVERT) || (s1.action == ACT_INDEX_BLEND)) begin
      col = s1.pal_ok ? pal_data : 32'd0;
    end else begin
      col = s1.color;
    end
    if ((s1.action == ACT_BGRA_BLEND) || (s1.action == ACT_INDEX_BLEND)) begin
      a_byte = col[31:24];
    end else begin
      a_byte = s1.code;
    end
    w     = widen_alpha(a_byte);
    ta    = (tint.alpha > TINT_ALPHA_ONE) ? TINT_ALPHA_ONE : tint.alpha;
    tprod = w * ta;
    s2_next.action = s1.action;
    s2_next.rgb    = col[23:0];
    s2_next.dst    = s1.dst;
    s2_next.conv   = convert_word(col);
    s2_next.alpha  = w;
    s2_next.tint_a = tprod[28:12];
  end

  // stage 2: backdrop and source products
  always_comb begin
    logic [ALPHA_W-1:0] a;
    logic [ALPHA_W-1:0] inv;
    logic [ALPHA_W-1:0] f;
    logic [15:0]        back;
    logic [7:0]         sr, sg, sb;
    a    = (s2.action == ACT_ALPHA_TINT) ? s2.tint_a : s2.alpha;
    inv  = ALPHA_ONE - a;
    back = swap16(s2.dst);
    unique case (s2.action)
      ACT_ALPHA_WHITE: begin
        sr = {3'd0, CHAN_FULL};
        sg = {3'd0, CHAN_FULL};
        sb = {3'd0, CHAN_FULL};
        f  = a;
      end
      ACT_ALPHA_TINT: begin
        sr = {3'd0, tint.red};
        sg = {3'd0, tint.green};
        sb = {3'd0, tint.blue};
        f  = a;
      end
      default: begin
        sr = s2.rgb[23:16];
        sg = s2.rgb[15:8];
        sb = s2.rgb[7:0];
        f  = {3'd0, a[ALPHA_W-1:3]};
      end
    endcase
    s3_next.conv_sel = (s2.action == ACT_BGRA_CONVERT) || (s2.action == ACT_INDEX_CONVERT);
    s3_next.conv     = s2.conv;
    s3_next.back_r   = back[4:0] * inv;
    s3_next.back_g   = back[10:6] * inv;
    s3_next.back_b   = back[15:11] * inv;
    s3_next.src_r    = sr * f;
    s3_next.src_g    = sg * f;
    s3_next.src_b    = sb * f;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2 <= s2_next;
    end
    if (rdy3) begin
      s3 <= s3_next;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_load && produces;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // stage 3: sum, keep five bits per channel and pack, or pass conv
  logic [24:0] sum_r, sum_g, sum_b;
  logic [15:0] pix_next;

  assign sum_r    = {3'd0, s3.back_r} + s3.src_r;
  assign sum_g    = {3'd0, s3.back_g} + s3.src_g;
  assign sum_b    = {3'd0, s3.back_b} + s3.src_b;
  assign pix_next = s3.conv_sel ? s3.conv
                  : swap16({sum_b[20:16], sum_g[20:16], 1'b0, sum_r[20:16]});

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_pixel <= pix_next;
    end
  end

endmodule

[sv/rgb555_pixel_blend_convert_top.sv]
// ----------------------------------------------------------------------------
// rgb555_pixel_blend_convert_top: byte-swapped rgb555 blend/convert engine
// Converts or blends BGRA, palette and alpha-only sources over a backdrop.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one request per pixel, carrying
//   action, src_color, src_code and dst_pixel. a palette write stores
//   src_color at slot src_code and gives no result; actions one to six
//   give one out_pixel each; the unused action gives nothing.
//   output channel (out_valid/out_ready): one out_pixel per result.
//   config channel (cfg_valid/cfg_ready): tint red, green, blue and alpha
//   at indexes 0 to 3, always ready; write only while the engine is idle.
//   throughput: one request per cycle unless the receiver stalls, set by
//   the single read port of the palette (one lookup a cycle) and the
//   three-stage multiply pipeline.
//   a palette entry written by one request can be read by the next.
//   reset clears the pipeline and loads full white, fully opaque tint;
//   the palette holds nothing defined until written, so no clearing pass.
//   when the receiver stalls, the output register holds its pixel and
//   the stages behind it keep filling bubbles before in_ready drops.
// ----------------------------------------------------------------------------
module rgb555_pixel_blend_convert_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     action,
  input  logic [31:0]                    src_color,
  input  logic [7:0]                     src_code,
  input  logic [15:0]                    dst_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpbc_pkg::*;

  tint_cfg_t   tint;
  pix_req_t    req;
  logic        in_fire;
  logic [31:0] pal_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint.red   <= CHAN_FULL;
      tint.green <= CHAN_FULL;
      tint.blue  <= CHAN_FULL;
      tint.alpha <= TINT_ALPHA_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TINT_RED:   tint.red   <= cfg_data[4:0];
        REG_TINT_GREEN: tint.green <= cfg_data[4:0];
        REG_TINT_BLUE:  tint.blue  <= cfg_data[4:0];
        REG_TINT_ALPHA: tint.alpha <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // request bundle
  assign in_fire    = in_valid && in_ready;
  assign req.action = action;
  assign req.color  = src_color;
  assign req.code   = src_code;
  assign req.dst    = dst_pixel;
  assign req.pal_ok = {1'b0, src_code} < 9'(PALETTE_ENTRIES);

  // palette store
  rpbc_palette_mem u_palette (
    .clk     (clk),
    .wr_en   (in_fire && (action == ACT_PAL_WRITE) && req.pal_ok),
    .wr_addr (src_code[PAL_IDX_W-1:0]),
    .wr_data (src_color),
    .rd_en   (in_fire),
    .rd_addr (src_code[PAL_IDX_W-1:0]),
    .rd_data (pal_data)
  );

  // blend and convert pipeline
  rpbc_blend_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_load   (in_fire),
    .req       (req),
    .in_ready  (in_ready),
    .pal_data  (pal_data),
    .tint      (tint),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel)
  );

endmodule
